[hdl/decimal_ascii_packet_framer_macros.svh]
// Assertion macros shared by the decimal ASCII packet framer modules.
`ifndef DECIMAL_ASCII_PACKET_FRAMER_MACROS_SVH
`define DECIMAL_ASCII_PACKET_FRAMER_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define DAP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dap assertion failed: same-cycle implication");
// Antecedent implies consequent in the next cycle.
`define DAP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dap assertion failed: next-cycle implication");
`else
`define DAP_ASSERT_IMP(label, ante, cons)
`define DAP_ASSERT_NXT(label, ante, cons)
`endif
`endif

[hdl/dap_pkg.sv]
// Types and constants of the decimal ASCII packet framer.
package dap_pkg;

  localparam int VALUE_W    = 16;
  localparam int ADDR_W     = 8;
  localparam int BYTE_W     = 8;
  localparam int DIGIT_W    = 4;

  // Largest digit count the digit part may hold, clamped to 1..9.
  localparam int MAX_DIGITS = 5;
  localparam int DIGIT_CAP  = (MAX_DIGITS < 1) ? 1 : ((MAX_DIGITS > 9) ? 9 : MAX_DIGITS);

  // A 16-bit number has at most five decimal digits.
  localparam int NUM_DIGITS = 5;
  localparam int EFF_CAP    = (DIGIT_CAP < NUM_DIGITS) ? DIGIT_CAP : NUM_DIGITS;
  localparam int DIV_STAGES = NUM_DIGITS - 1;
  localparam int COUNT_W    = $clog2(NUM_DIGITS + 1);
  localparam int IDX_W      = $clog2(NUM_DIGITS);
  localparam int SUM_W      = $clog2(9 * NUM_DIGITS + 1);

  // x / 10 == (x * 52429) >> 19 for every 16-bit x.
  localparam logic [VALUE_W-1:0] RECIP       = 16'd52429;
  localparam int                 RECIP_SHIFT = 19;
  // s / 10 == (s * 13) >> 7 for every digit sum up to 45.
  localparam logic [SUM_W-1:0]   SUM_RECIP   = 6'd13;
  localparam int                 SUM_SHIFT   = 7;

  localparam logic [BYTE_W-1:0]  ASCII_ZERO  = 8'h30;

  typedef logic [DIGIT_W-1:0]           digit_t;
  typedef digit_t [NUM_DIGITS-1:0]      digit_vec_t;

  // Record carried through the conversion stages.
  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [VALUE_W-1:0] rem;
    digit_vec_t         digits;
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   sum;
  } dap_work_t;

  // Finished packet description handed to the serializer.
  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    digit_vec_t         digits;
    logic [COUNT_W-1:0] count;
    digit_t             sum_hi;
    digit_t             sum_lo;
  } dap_pkt_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ADDR,
    PH_LEN,
    PH_DIGIT,
    PH_SUM_HI,
    PH_SUM_LO
  } dap_phase_t;

endpackage

[hdl/dap_in_if.sv]
// Input channel: a number and its address byte.
interface dap_in_if;
  import dap_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [ADDR_W-1:0]  address_byte;

  modport source (output valid, output value, output address_byte, input ready);
  modport sink   (input valid, input value, input address_byte, output ready);
endinterface

[hdl/dap_out_if.sv]
// Output channel: one packet byte per transaction.
interface dap_out_if;
  import dap_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] tx_byte;
  logic              last_byte;

  modport source (output valid, output tx_byte, output last_byte, input ready);
  modport sink   (input valid, input tx_byte, input last_byte, output ready);
endinterface

[hdl/dap_digit_pipe.sv]
// Pipelined binary to decimal conversion, digit count and digit sum.
`include "decimal_ascii_packet_framer_macros.svh"
module dap_digit_pipe (
  input  logic              clk,
  input  logic              rst,
  dap_in_if.sink            din,
  output logic              pkt_v,
  output dap_pkg::dap_pkt_t pkt,
  input  logic              pkt_ready
);
  import dap_pkg::*;

  // Division stages, one decimal digit each.
  logic      wk_v   [DIV_STAGES];
  dap_work_t wk     [DIV_STAGES];
  logic      wk_adv [DIV_STAGES];

  // Count, sum and split stages.
  logic      cnt_v;
  dap_work_t cnt_rec;
  logic      cnt_adv;
  logic      sm_v;
  dap_work_t sm_rec;
  logic      sm_adv;
  logic      pkt_adv;

  dap_work_t in_rec;
  dap_work_t cnt_next;
  dap_work_t sm_next;
  dap_pkt_t  pkt_next;
  logic [SUM_W+SUM_SHIFT-1:0] tens_prod;
  logic [SUM_W-1:0]           tens;

  // Each stage loads when it is empty or its successor moves on.
  assign pkt_adv = !pkt_v || pkt_ready;
  assign sm_adv  = !sm_v  || pkt_adv;
  assign cnt_adv = !cnt_v || sm_adv;
  assign din.ready = wk_adv[0];

  always_comb begin
    in_rec = '0;
    in_rec.addr = din.address_byte;
    in_rec.rem  = din.value;
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    dap_work_t                src;
    logic                     src_v;
    logic                     nxt_adv;
    dap_work_t                res;
    logic [2*VALUE_W-1:0]     prod;
    logic [VALUE_W-1:0]       quo;
    logic [VALUE_W-1:0]       quo10;
    logic [VALUE_W-1:0]       rmd;

    if (k == 0) begin : g_first
      assign src   = in_rec;
      assign src_v = din.valid;
    end else begin : g_next
      assign src   = wk[k-1];
      assign src_v = wk_v[k-1];
    end

    if (k == DIV_STAGES - 1) begin : g_tail
      assign nxt_adv = cnt_adv;
    end else begin : g_body
      assign nxt_adv = wk_adv[k+1];
    end

    assign wk_adv[k] = !wk_v[k] || nxt_adv;

    // Quotient by reciprocal multiply, remainder by shift-and-add subtract.
    assign prod  = src.rem * RECIP;
    assign quo   = VALUE_W'(prod >> RECIP_SHIFT);
    assign quo10 = (quo << 3) + (quo << 1);
    assign rmd   = src.rem - quo10;

    always_comb begin
      res           = src;
      res.rem       = quo;
      res.digits[k] = rmd[DIGIT_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        wk_v[k] <= 1'b0;
      end else if (wk_adv[k]) begin
        wk_v[k] <= src_v;
      end
      if (wk_adv[k]) begin
        wk[k] <= res;
      end
    end
  end

  // Top digit is what is left; count the digits up to the highest nonzero one, capped at EFF_CAP.
  always_comb begin
    cnt_next = wk[DIV_STAGES-1];
    cnt_next.digits[NUM_DIGITS-1] = wk[DIV_STAGES-1].rem[DIGIT_W-1:0];
    cnt_next.count = COUNT_W'(1);
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (cnt_next.digits[i] != '0) begin
        cnt_next.count = COUNT_W'(i + 1);
      end
    end
    if (cnt_next.count > COUNT_W'(EFF_CAP)) begin
      cnt_next.count = COUNT_W'(EFF_CAP);
    end
  end

  // Sum of the digits that are sent.
  always_comb begin
    sm_next = cnt_rec;
    sm_next.sum = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (COUNT_W'(i) < cnt_rec.count) begin
        sm_next.sum = sm_next.sum + SUM_W'(cnt_rec.digits[i]);
      end
    end
  end

  // Split the sum into tens and ones.
  assign tens_prod = (SUM_W+SUM_SHIFT)'(sm_rec.sum) * (SUM_W+SUM_SHIFT)'(SUM_RECIP);
  assign tens      = SUM_W'(tens_prod >> SUM_SHIFT);

  always_comb begin
    pkt_next.addr   = sm_rec.addr;
    pkt_next.digits = sm_rec.digits;
    pkt_next.count  = sm_rec.count;
    pkt_next.sum_hi = tens[DIGIT_W-1:0];
    pkt_next.sum_lo = DIGIT_W'(sm_rec.sum - ((tens << 3) + (tens << 1)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_v <= 1'b0;
      sm_v  <= 1'b0;
      pkt_v <= 1'b0;
    end else begin
      if (cnt_adv) begin
        cnt_v <= wk_v[DIV_STAGES-1];
      end
      if (sm_adv) begin
        sm_v <= cnt_v;
      end
      if (pkt_adv) begin
        pkt_v <= sm_v;
      end
    end
    if (cnt_adv) begin
      cnt_rec <= cnt_next;
    end
    if (sm_adv) begin
      sm_rec <= sm_next;
    end
    if (pkt_adv) begin
      pkt <= pkt_next;
    end
  end

  `DAP_ASSERT_IMP(a_count_range, pkt_v, (pkt.count >= COUNT_W'(1)) && (pkt.count <= COUNT_W'(EFF_CAP)))
  `DAP_ASSERT_IMP(a_sum_digits, pkt_v, (pkt.sum_lo <= DIGIT_W'(9)) && (pkt.sum_hi <= DIGIT_W'(4)))
  `DAP_ASSERT_NXT(a_pkt_held, pkt_v && !pkt_ready, pkt_v && $stable(pkt))

endmodule

[hdl/dap_serializer.sv]
// Byte serializer: turns one packet description into its byte stream.
`include "decimal_ascii_packet_framer_macros.svh"
module dap_serializer (
  input  logic              clk,
  input  logic              rst,
  input  logic              pkt_v,
  input  dap_pkg::dap_pkt_t pkt_in,
  output logic              pkt_ready,
  dap_out_if.source         dout
);
  import dap_pkg::*;

  dap_phase_t         phase;
  dap_phase_t         phase_next;
  dap_pkt_t           pkt_q;
  logic [IDX_W-1:0]   idx;
  logic               ov;
  logic [BYTE_W-1:0]  obyte;
  logic               olast;

  logic               emit;
  logic               pkt_take;
  logic [BYTE_W-1:0]  cur_byte;
  logic               cur_last;

  assign dout.valid     = ov;
  assign dout.tx_byte   = obyte;
  assign dout.last_byte = olast;

  // A byte moves into the output register when it is empty or being taken.
  assign emit      = (phase != PH_IDLE) && (!ov || dout.ready);
  assign pkt_ready = (phase == PH_IDLE) || (emit && cur_last);
  assign pkt_take  = pkt_v && pkt_ready;

  // Byte for the current phase.
  always_comb begin
    cur_byte = ASCII_ZERO;
    cur_last = 1'b0;
    unique case (phase)
      PH_IDLE:   cur_byte = ASCII_ZERO;
      PH_ADDR:   cur_byte = pkt_q.addr;
      PH_LEN:    cur_byte = ASCII_ZERO + BYTE_W'(pkt_q.count);
      PH_DIGIT:  cur_byte = ASCII_ZERO + BYTE_W'(pkt_q.digits[idx]);
      PH_SUM_HI: cur_byte = ASCII_ZERO + BYTE_W'(pkt_q.sum_hi);
      PH_SUM_LO: begin
        cur_byte = ASCII_ZERO + BYTE_W'(pkt_q.sum_lo);
        cur_last = 1'b1;
      end
      default:   cur_byte = ASCII_ZERO;
    endcase
  end

  // Phase sequence; the digit phase walks from the top digit down to digit zero.
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: begin
        if (pkt_v) phase_next = PH_ADDR;
      end
      PH_ADDR: begin
        if (emit) phase_next = PH_LEN;
      end
      PH_LEN: begin
        if (emit) phase_next = PH_DIGIT;
      end
      PH_DIGIT: begin
        if (emit && idx == '0) begin
          phase_next = (pkt_q.sum_hi != '0) ? PH_SUM_HI : PH_SUM_LO;
        end
      end
      PH_SUM_HI: begin
        if (emit) phase_next = PH_SUM_LO;
      end
      PH_SUM_LO: begin
        if (emit) phase_next = pkt_v ? PH_ADDR : PH_IDLE;
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      ov    <= 1'b0;
    end else begin
      phase <= phase_next;
      if (emit) begin
        ov <= 1'b1;
      end else if (dout.ready) begin
        ov <= 1'b0;
      end
    end
    if (emit) begin
      obyte <= cur_byte;
      olast <= cur_last;
    end
    if (pkt_take) begin
      pkt_q <= pkt_in;
      idx   <= IDX_W'(pkt_in.count - COUNT_W'(1));
    end else if (emit && phase == PH_DIGIT) begin
      idx <= idx - IDX_W'(1);
    end
  end

  `DAP_ASSERT_NXT(a_take_starts_addr, pkt_take, phase == PH_ADDR)
  `DAP_ASSERT_NXT(a_last_ends_packet, emit && cur_last && !pkt_v, phase == PH_IDLE)
  `DAP_ASSERT_IMP(a_idx_in_count, phase == PH_DIGIT, COUNT_W'(idx) < pkt_q.count)

endmodule

[hdl/decimal_ascii_packet_framer.sv]
// A number's address byte passes the conversion pipeline, the serializer's packet register and its output register.
// Throughput: one byte per cycle while the output is ready; a packet has 4 to 9 bytes.
// The byte serializer sets the pace; the 7-stage conversion pipeline keeps packets queued.
// Back-to-back packets leave no idle cycle between them when the next packet is already waiting.
// Reset (synchronous, active high) empties the pipeline and the output register.
module decimal_ascii_packet_framer (
  input  logic      clk,
  input  logic      rst,
  dap_in_if.sink    din,
  dap_out_if.source dout
);
  import dap_pkg::*;

  logic     pkt_v;
  logic     pkt_ready;
  dap_pkt_t pkt;

  // Decimal conversion, digit count and digit sum.
  dap_digit_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .din       (din),
    .pkt_v     (pkt_v),
    .pkt       (pkt),
    .pkt_ready (pkt_ready)
  );

  // Packet byte stream.
  dap_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .pkt_v     (pkt_v),
    .pkt_in    (pkt),
    .pkt_ready (pkt_ready),
    .dout      (dout)
  );

endmodule
